### hw/rtl/cgwt_pkg.sv
// Shared constants, codes and types for the coding generation window tracker.
`timescale 1ns / 1ps
`default_nettype none

package cgwt_pkg;

    // Window geometry
    localparam int NUM_GENERATIONS = 4;
    localparam int MAX_GEN_FRAMES  = 64;
    localparam int SLOT_W          = $clog2(NUM_GENERATIONS);
    localparam int POS_W           = $clog2(NUM_GENERATIONS + 1);

    // Field widths
    localparam int ACTION_W = 2;
    localparam int LEN_W    = 16;
    localparam int SEQ_W    = 16;
    localparam int FILL_W   = 7;
    localparam int RWS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int PIVOT_W  = 6;
    localparam int ADV_W    = 5;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_PER_GEN = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_FRAME_BYTES = 1'd1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ALIGN = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNAVAIL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_OVERLAP = 2'd3;

    // Verdict on one slot against the current generation size
    typedef struct packed {
        logic              has_space;
        logic              complete;
        logic [FILL_W-1:0] forced_acked;
    } slot_eval_t;

endpackage

`default_nettype wire

### hw/rtl/coding_generation_window_tracker_core.sv
// Top level of the coding generation window tracker (source side).
`timescale 1ns / 1ps
`default_nettype none

// The tracker keeps a ring of NUM_GENERATIONS generation slots with contiguous
// sequence numbers and handles one transaction at a time: add a frame, apply an
// acknowledgment entry, or align to the remote window id. Every input transaction
// yields exactly one result transaction. A single slot port with one evaluator
// steps through the ring one slot per cycle (search for space, forcing slots
// complete, recycling from the head), so a transaction's length depends on its work:
// an oversize frame or a plain ack only decodes, while an add with the window
// full scans, forces, advances and rescans. s_tready is high only while
// no transaction is in work and reset is released; a finished result waits in
// the output register and does not block the next input. Configuration writes
// are taken at any time but should be made while the block is idle.

module coding_generation_window_tracker_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [cgwt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cgwt_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_length[15:0], seq_in[31:16], ack_dimension[38:32],
    // remote_window_size[43:39], zero fill[47:44]
    input  logic [cgwt_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [cgwt_pkg::ACTION_W-1:0]    s_tuser,
    // last_entry
    input  logic                             s_tlast,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // used_seq[15:0], used_pivot[21:16], window_base[37:22], advanced[42:38],
    // remote_done[43], zero fill[47:44]
    output logic [cgwt_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [cgwt_pkg::STATUS_W-1:0]    m_tuser
);
    import cgwt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FORCE  = 3'd3;
    localparam logic [2:0] S_ADV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    // Ring position k places after the head
    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] head,
                                                  input logic [SLOT_W-1:0] k);
        logic [SLOT_W:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= (SLOT_W + 1)'(NUM_GENERATIONS)) begin
            sum = sum - (SLOT_W + 1)'(NUM_GENERATIONS);
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Configuration registers
    logic [FILL_W-1:0]   frames_per_gen_reg;
    logic [LEN_W-1:0]    max_frame_bytes_reg;

    // Window state
    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg  [NUM_GENERATIONS];
    logic [FILL_W-1:0]   fill_next [NUM_GENERATIONS];
    logic [FILL_W-1:0]   acked_reg  [NUM_GENERATIONS];
    logic [FILL_W-1:0]   acked_next [NUM_GENERATIONS];

    // Sequencer
    logic [2:0]          state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    limit_reg, limit_next;
    logic [POS_W-1:0]    adv_cnt_reg, adv_cnt_next;
    logic                retry_reg, retry_next;

    // Latched transaction
    logic [ACTION_W-1:0] action_reg;
    logic [LEN_W-1:0]    flen_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [FILL_W-1:0]   dim_reg;
    logic                last_reg;
    logic [RWS_W-1:0]    rws_reg;

    // Result under construction
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SEQ_W-1:0]    used_seq_reg, used_seq_next;
    logic [PIVOT_W-1:0]  pivot_reg, pivot_next;
    logic                done_reg, done_next;

    // Output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic                out_load;

    // Shared slot port
    logic [FILL_W-1:0]   gen_size;
    logic [SEQ_W-1:0]    dist_fwd;
    logic [SEQ_W-1:0]    dist_back;
    logic [SEQ_W-1:0]    dist_min;
    logic [SLOT_W-1:0]   slot_idx;
    logic [FILL_W-1:0]   slot_fill;
    logic [FILL_W-1:0]   slot_acked;
    logic [FILL_W-1:0]   fill_inc;
    logic [FILL_W-1:0]   ack_max;
    slot_eval_t          slot_ev;

    // Clamp the generation size to its legal range
    always_comb begin
        if (frames_per_gen_reg == '0) begin
            gen_size = FILL_W'(1);
        end else if (32'(frames_per_gen_reg) > MAX_GEN_FRAMES) begin
            gen_size = FILL_W'(MAX_GEN_FRAMES);
        end else begin
            gen_size = frames_per_gen_reg;
        end
    end

    // Circular distances between the latched sequence number and the base
    assign dist_fwd  = seq_reg - base_reg;
    assign dist_back = base_reg - seq_reg;
    assign dist_min  = (dist_fwd < dist_back) ? dist_fwd : dist_back;

    // Select the one slot the sequencer works on this cycle
    always_comb begin
        case (state_reg)
            S_DECODE: slot_idx = slot_at(head_reg, dist_fwd[SLOT_W-1:0]);
            S_SCAN,
            S_FORCE:  slot_idx = slot_at(head_reg, pos_reg[SLOT_W-1:0]);
            default:  slot_idx = head_reg;
        endcase
    end

    assign slot_fill  = fill_reg[slot_idx];
    assign slot_acked = acked_reg[slot_idx];
    assign fill_inc   = slot_fill + FILL_W'(1);
    assign ack_max    = (dim_reg > slot_acked) ? dim_reg : slot_acked;

    cgwt_slot_eval u_slot_eval (
        .fill     (slot_fill),
        .acked    (slot_acked),
        .gen_size (gen_size),
        .eval_o   (slot_ev)
    );

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Sequencer and window update
    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        limit_next    = limit_reg;
        adv_cnt_next  = adv_cnt_reg;
        retry_next    = retry_reg;
        base_next     = base_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        acked_next    = acked_reg;
        status_next   = status_reg;
        used_seq_next = used_seq_reg;
        pivot_next    = pivot_reg;
        done_next     = done_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    status_next   = ST_OK;
                    used_seq_next = '0;
                    pivot_next    = '0;
                    done_next     = 1'b0;
                    adv_cnt_next  = '0;
                    retry_next    = 1'b0;
                    pos_next      = '0;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE: begin
                case (action_reg)
                    ACT_ADD: begin
                        // drop oversize frames, else search for space
                        if (flen_reg > max_frame_bytes_reg) begin
                            status_next = ST_TOO_LARGE;
                            state_next  = S_OUT;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    ACT_ACK: begin
                        // raise the acknowledged dimension of a slot in the window
                        if (dist_fwd < SEQ_W'(NUM_GENERATIONS)) begin
                            acked_next[slot_idx] = ack_max;
                            used_seq_next        = seq_reg;
                            done_next            = (ack_max >= slot_fill);
                        end else begin
                            status_next = ST_UNAVAIL;
                        end
                        state_next = last_reg ? S_ADV : S_OUT;
                    end
                    ACT_ALIGN: begin
                        // force the slots between the head and the remote window id complete
                        state_next = S_OUT;
                        if (dist_min != '0) begin
                            if (dist_min >= SEQ_W'(rws_reg)) begin
                                status_next = ST_NO_OVERLAP;
                            end else if (dist_fwd < SEQ_W'(NUM_GENERATIONS)) begin
                                limit_next = dist_fwd[POS_W-1:0];
                                state_next = S_FORCE;
                            end
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_SCAN: begin
                // place the frame in the first slot with space
                if (slot_ev.has_space) begin
                    fill_next[slot_idx] = fill_inc;
                    pivot_next          = slot_fill[PIVOT_W-1:0];
                    used_seq_next       = base_reg + SEQ_W'(pos_reg);
                    done_next           = (slot_acked >= fill_inc);
                    state_next          = S_OUT;
                end else if (pos_reg == POS_W'(NUM_GENERATIONS - 1)) begin
                    if (retry_reg) begin
                        status_next = ST_UNAVAIL;
                        state_next  = S_OUT;
                    end else begin
                        // window full: force the head complete and advance
                        pos_next   = '0;
                        limit_next = POS_W'(1);
                        state_next = S_FORCE;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end

            S_FORCE: begin
                fill_next[slot_idx]  = gen_size;
                acked_next[slot_idx] = slot_ev.forced_acked;
                if (pos_reg + POS_W'(1) == limit_reg) begin
                    state_next = S_ADV;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end

            S_ADV: begin
                // recycle complete slots from the head
                if ((adv_cnt_reg < POS_W'(NUM_GENERATIONS)) && slot_ev.complete) begin
                    fill_next[slot_idx]  = '0;
                    acked_next[slot_idx] = '0;
                    head_next            = slot_at(head_reg, SLOT_W'(1));
                    base_next            = base_reg + SEQ_W'(1);
                    adv_cnt_next         = adv_cnt_reg + POS_W'(1);
                end else if (action_reg == ACT_ADD) begin
                    retry_next = 1'b1;
                    pos_next   = '0;
                    state_next = S_SCAN;
                end else begin
                    state_next = S_OUT;
                end
            end

            S_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, window state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            m_tvalid_reg        <= 1'b0;
            base_reg            <= '0;
            head_reg            <= '0;
            pos_reg             <= '0;
            limit_reg           <= '0;
            adv_cnt_reg         <= '0;
            retry_reg           <= 1'b0;
            frames_per_gen_reg  <= FILL_W'(16);
            max_frame_bytes_reg <= LEN_W'(1500);
            for (int i = 0; i < NUM_GENERATIONS; i++) begin
                fill_reg[i]  <= '0;
                acked_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            base_reg     <= base_next;
            head_reg     <= head_next;
            pos_reg      <= pos_next;
            limit_reg    <= limit_next;
            adv_cnt_reg  <= adv_cnt_next;
            retry_reg    <= retry_next;
            fill_reg     <= fill_next;
            acked_reg    <= acked_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FRAMES_PER_GEN:  frames_per_gen_reg  <= cfg_wr_data[FILL_W-1:0];
                    REG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg_wr_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Latch the accepted transaction and the result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            flen_reg   <= s_tdata[15:0];
            seq_reg    <= s_tdata[31:16];
            dim_reg    <= s_tdata[38:32];
            last_reg   <= s_tlast;
            rws_reg    <= s_tdata[43:39];
        end
        status_reg   <= status_next;
        used_seq_reg <= used_seq_next;
        pivot_reg    <= pivot_next;
        done_reg     <= done_next;
        if (out_load) begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {4'b0, done_reg, ADV_W'(adv_cnt_reg), base_reg,
                            pivot_reg, used_seq_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### hw/rtl/cgwt_slot_eval.sv
// Slot evaluator: fullness, completeness and forced-complete value of one slot.
`timescale 1ns / 1ps
`default_nettype none

module cgwt_slot_eval (
    input  logic [cgwt_pkg::FILL_W-1:0] fill,
    input  logic [cgwt_pkg::FILL_W-1:0] acked,
    input  logic [cgwt_pkg::FILL_W-1:0] gen_size,
    output cgwt_pkg::slot_eval_t        eval_o
);
    import cgwt_pkg::*;

    // Compare the slot against the generation size
    always_comb begin
        eval_o.has_space    = (fill < gen_size);
        eval_o.complete     = (fill >= gen_size) && (acked >= gen_size);
        eval_o.forced_acked = (acked < gen_size) ? gen_size : acked;
    end

endmodule

`default_nettype wire
